// ----- hw/rtl/rrpr_pkg.sv -----
package rrpr_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdBits   = 16;
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);
  localparam int unsigned IdxW     = $clog2(MaxTasks);

  typedef enum logic [1:0] {
    OpCreate   = 2'd0,
    OpSchedule = 2'd1,
    OpLookup   = 2'd2,
    OpRetire   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StFull     = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    op_e               opcode;
    logic [IdBits-1:0] task_id;
    logic              finished;
  } in_req_t;

  typedef struct packed {
    logic [IdBits-1:0] result_id;
    status_e           status;
    logic              removed;
    logic [CntW-1:0]   task_count;
    logic              nonempty;
  } out_rsp_t;

  // broadcast to every cell of the ring
  typedef struct packed {
    logic              scan;
    logic              write;
    logic              shift;
    logic [CntW-1:0]   count;
    logic [IdxW-1:0]   pos;
    logic [IdBits-1:0] key;
    logic [IdBits-1:0] new_id;
  } cell_bus_t;

endpackage

// ----- hw/rtl/rrpr_cell.sv -----
module rrpr_cell #(
  parameter int unsigned CellIdx = 0
) (
  input  logic                      clk_i,
  input  rrpr_pkg::cell_bus_t       bus_i,
  input  logic [rrpr_pkg::IdBits-1:0] nb_id_i,
  output logic [rrpr_pkg::IdBits-1:0] id_o,
  output logic                      hit_o
);
  import rrpr_pkg::*;

  localparam logic [CntW-1:0] MyCnt = CntW'(CellIdx);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [IdBits-1:0] id_q, id_d;
  logic              hit_q, hit_d;
  logic              occupied;

  assign occupied = (MyCnt < bus_i.count);

  always_comb begin
    id_d  = id_q;
    hit_d = hit_q;
    if (bus_i.scan) begin
      hit_d = occupied && (id_q == bus_i.key);
    end
    if (bus_i.write && (MyCnt == bus_i.count)) begin
      id_d = bus_i.new_id;
    end else if (bus_i.shift && (MyIdx >= bus_i.pos)) begin
      id_d = nb_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    hit_q <= hit_d;
  end

  assign id_o  = id_q;
  assign hit_o = hit_q;

endmodule

// ----- hw/rtl/round_robin_process_ring_core.sv -----
// Round-robin task ring.
// Input channel in_valid_i/in_ready_o carries one request (in_req_t): create,
// schedule, lookup or retire. Output channel out_valid_o/out_ready_i returns
// exactly one response (out_rsp_t) per request, in order.
// Ids live in a row of cells, one id per cell in insertion order; a retire
// shifts the cells above the removed entry down by one, all together.
// Timing: a request is taken in the idle cycle, all cells compare the key in
// the next cycle, and the decide state then applies the update and loads the
// output register. A new request is taken only after the previous one has
// passed through the scan and decide states of the sequencer.
// in_ready_o is high only while no request is in flight. A waiting response
// does not block the next accept; if the receiver still holds the previous
// response when the next one is ready, the update waits until it is taken.
// Reset clears the count and the current pointer and sets the id counter to 1;
// the cell contents are left as they are and are never read before written.
module round_robin_process_ring_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rrpr_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rrpr_pkg::out_rsp_t out_rsp_o
);
  import rrpr_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StScan   = 3'b010,
    StDecide = 3'b100
  } state_e;

  state_e            state_q, state_d;
  in_req_t           req_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdBits-1:0] idc_q, idc_d;
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_rsp_q, out_rsp_d;

  cell_bus_t               bus;
  logic [IdBits-1:0]       ids [MaxTasks];
  logic [MaxTasks-1:0]     hits, first;
  logic [IdxW-1:0]         pos;
  logic                    found, fire, accept;
  logic [CntW-1:0]         cnt_m1, cur_ext, nxt_cur;
  logic [IdxW-1:0]         cur_adj;
  logic [IdBits-1:0]       idc_inc;

  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    logic [IdBits-1:0] nb;
    if (g == MaxTasks - 1) begin : g_last
      assign nb = ids[g];
    end else begin : g_mid
      assign nb = ids[g+1];
    end
    rrpr_cell #(.CellIdx(g)) u_cell (
      .clk_i  (clk_i),
      .bus_i  (bus),
      .nb_id_i(nb),
      .id_o   (ids[g]),
      .hit_o  (hits[g])
    );
  end

  assign first = hits & (~hits + {{(MaxTasks-1){1'b0}}, 1'b1});
  assign found = |hits;

  always_comb begin
    pos = '0;
    for (int i = 0; i < MaxTasks; i++) begin
      if (first[i]) begin
        pos = pos | IdxW'(i);
      end
    end
  end

  assign accept = in_valid_i && in_ready_o;
  assign fire   = (state_q == StDecide) && (!out_valid_q || out_ready_i);
  assign cnt_m1  = count_q - CntW'(1);
  assign cur_ext = CntW'(cur_q);
  assign nxt_cur = cur_ext + CntW'(1);
  assign cur_adj = (cur_q > pos) ? (cur_q - IdxW'(1)) : cur_q;
  assign idc_inc = idc_q + IdBits'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    idc_d       = idc_q;
    out_rsp_d   = out_rsp_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    bus.scan   = (state_q == StScan);
    bus.write  = 1'b0;
    bus.shift  = 1'b0;
    bus.count  = count_q;
    bus.pos    = pos;
    bus.key    = req_q.task_id;
    bus.new_id = idc_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StScan;
        end
      end
      StScan: begin
        state_d = StDecide;
      end
      StDecide: begin
        if (fire) begin
          state_d              = StIdle;
          out_valid_d          = 1'b1;
          out_rsp_d.result_id  = req_q.task_id;
          out_rsp_d.status     = StOk;
          out_rsp_d.removed    = 1'b0;
          unique case (req_q.opcode)
            OpCreate: begin
              if (count_q == CntW'(MaxTasks)) begin
                out_rsp_d.status    = StFull;
                out_rsp_d.result_id = '0;
              end else begin
                bus.write           = 1'b1;
                out_rsp_d.result_id = idc_q;
                count_d             = count_q + CntW'(1);
                idc_d               = (idc_inc == '0) ? IdBits'(1) : idc_inc;
              end
            end
            OpSchedule: begin
              if (count_q == '0) begin
                out_rsp_d.status    = StEmpty;
                out_rsp_d.result_id = '0;
              end else begin
                out_rsp_d.result_id = ids[cur_q];
                cur_d = (nxt_cur >= count_q) ? '0 : nxt_cur[IdxW-1:0];
              end
            end
            OpLookup: begin
              if (!found) begin
                out_rsp_d.status = StNotFound;
              end
            end
            OpRetire: begin
              if (!found) begin
                out_rsp_d.status = StNotFound;
              end else if (req_q.finished) begin
                bus.shift         = 1'b1;
                out_rsp_d.removed = 1'b1;
                count_d           = cnt_m1;
                if (cnt_m1 == '0 || CntW'(cur_adj) >= cnt_m1) begin
                  cur_d = '0;
                end else begin
                  cur_d = cur_adj;
                end
              end
            end
            default: ;
          endcase
          out_rsp_d.task_count = count_d;
          out_rsp_d.nonempty   = (count_d != '0);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      cur_q       <= '0;
      idc_q       <= IdBits'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      idc_q       <= idc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    out_rsp_q <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- hw/rtl/rrpr_checker.sv -----
module rrpr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input rrpr_pkg::out_rsp_t out_rsp_i
);
  import rrpr_pkg::*;

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after accept");

  // a response only appears while a request is being worked on
  a_rsp_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("response without request in flight");

  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_rsp_i.status == StEmpty |->
      !out_rsp_i.nonempty && out_rsp_i.result_id == '0 && out_rsp_i.task_count == '0)
    else $error("empty response inconsistent");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rsp_i))
    else $error("stalled response changed");

endmodule

bind round_robin_process_ring_core rrpr_checker u_rrpr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_i  (out_rsp_o)
);

// ----- bench/round_robin_process_ring_core_test.sv -----
module round_robin_process_ring_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rrpr_pkg::*;

  localparam int unsigned StallLimit = 2000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_rsp;

  round_robin_process_ring_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // ring shadow
  logic [IdBits-1:0] ring_ids[MaxTasks];
  int unsigned       ring_len;
  int unsigned       cur_pos;
  logic [IdBits-1:0] next_id;

  out_rsp_t pending_rsp[$];

  bit tx_idle_en;
  bit rx_stall_en;
  int hold_len;
  int stall_cycles;
  int mismatches;
  int req_total;
  int op_seen[4];
  int full_hits, empty_hits, miss_hits, removals, id_wraps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic int find_id(logic [IdBits-1:0] id);
    for (int i = 0; i < ring_len; i++) begin
      if (ring_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic out_rsp_t ring_apply(in_req_t req);
    out_rsp_t rsp;
    int pos;
    rsp = '0;
    rsp.status = StOk;
    case (req.opcode)
      OpCreate: begin
        if (ring_len >= MaxTasks) begin
          rsp.status = StFull;
        end else begin
          rsp.result_id = next_id;
          ring_ids[ring_len] = next_id;
          ring_len++;
          next_id++;
          if (next_id == '0) begin
            next_id = 1;
            id_wraps++;
          end
        end
      end
      OpSchedule: begin
        if (ring_len == 0) begin
          rsp.status = StEmpty;
        end else begin
          rsp.result_id = ring_ids[cur_pos];
          cur_pos++;
          if (cur_pos >= ring_len) cur_pos = 0;
        end
      end
      OpLookup: begin
        rsp.result_id = req.task_id;
        if (find_id(req.task_id) < 0) rsp.status = StNotFound;
      end
      default: begin
        rsp.result_id = req.task_id;
        pos = find_id(req.task_id);
        if (pos < 0) begin
          rsp.status = StNotFound;
        end else if (req.finished) begin
          for (int i = pos; i + 1 < ring_len; i++) ring_ids[i] = ring_ids[i + 1];
          ring_len--;
          if (ring_len == 0) begin
            cur_pos = 0;
          end else begin
            if (cur_pos > pos) cur_pos--;
            if (cur_pos >= ring_len) cur_pos = 0;
          end
          rsp.removed = 1'b1;
        end
      end
    endcase
    rsp.task_count = CntW'(ring_len);
    rsp.nonempty   = (ring_len != 0);
    return rsp;
  endfunction

  task automatic send_req(input op_e op, input logic [IdBits-1:0] id, input logic fin);
    in_req_t  req;
    out_rsp_t want;
    int       gap;
    req.opcode   = op;
    req.task_id  = id;
    req.finished = fin;
    in_req   <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    want = ring_apply(req);
    pending_rsp.push_back(want);
    req_total++;
    op_seen[op]++;
    case (want.status)
      StFull:     full_hits++;
      StEmpty:    empty_hits++;
      StNotFound: miss_hits++;
      default:    if (want.removed) removals++;
    endcase
    gap = (tx_idle_en && $urandom_range(0, 1)) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver side
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_ready <= 1'b1;
      end else if (rx_stall_en && $urandom_range(0, 9) < 3) begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with no request pending: id=%h st=%0d rm=%b cnt=%0d ne=%b",
                   $time, out_rsp.result_id, out_rsp.status, out_rsp.removed,
                   out_rsp.task_count, out_rsp.nonempty);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.result_id !== want.result_id || out_rsp.status !== want.status ||
            out_rsp.removed !== want.removed || out_rsp.task_count !== want.task_count ||
            out_rsp.nonempty !== want.nonempty) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"%0t: mismatch exp id=%h st=%0d rm=%b cnt=%0d ne=%b",
                      " got id=%h st=%0d rm=%b cnt=%0d ne=%b"}, $time,
                     want.result_id, want.status, want.removed, want.task_count,
                     want.nonempty, out_rsp.result_id, out_rsp.status, out_rsp.removed,
                     out_rsp.task_count, out_rsp.nonempty);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("round_robin_process_ring_core_test: errors");
      $finish;
    end
  end

  task automatic test_empty_ring();
    send_req(OpSchedule, 16'($urandom), 1'b1);
    send_req(OpLookup, 16'h0000, 1'b0);
    send_req(OpLookup, 16'hffff, 1'b1);
    send_req(OpRetire, 16'hffff, 1'b1);
  endtask

  task automatic test_fill_to_full();
    repeat (MaxTasks) send_req(OpCreate, 16'($urandom), 1'($urandom));
    send_req(OpCreate, 16'hffff, 1'b1);
  endtask

  task automatic test_retire_paths();
    send_req(OpSchedule, 16'h0000, 1'b0);
    send_req(OpSchedule, 16'hffff, 1'b1);
    send_req(OpRetire, 16'd3, 1'b0);      // present, not finished
    send_req(OpRetire, 16'd3, 1'b1);      // current entry
    send_req(OpSchedule, 16'h0000, 1'b0);
    send_req(OpRetire, 16'd16, 1'b1);     // tail
    send_req(OpRetire, 16'd1, 1'b1);      // head
    send_req(OpLookup, 16'd1, 1'b0);
    send_req(OpLookup, 16'd2, 1'b0);
    wait_drained();
  endtask

  // create and retire at the tail over and over, with a schedule in between
  task automatic test_churn();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    repeat (16) begin
      send_req(OpCreate, 16'($urandom), 1'($urandom));
      send_req(OpRetire, ring_ids[ring_len - 1], 1'b1);
      send_req(OpSchedule, 16'($urandom), 1'($urandom));
    end
    wait_drained();
  endtask

  task automatic random_phase(int n, bit tx_idle, bit rx_stall, bit draining);
    int r, c;
    op_e op;
    logic [IdBits-1:0] id;
    logic fin;
    tx_idle_en  = tx_idle;
    rx_stall_en = rx_stall;
    repeat (n) begin
      c = draining ? 10 : (ring_len < 4) ? 50 : (ring_len > 12) ? 10 : 30;
      r = $urandom_range(0, 99);
      op = (r < c) ? OpCreate : op_e'($urandom_range(1, 3));
      if (ring_len != 0 && $urandom_range(0, 9) < 7)
        id = ring_ids[$urandom_range(0, ring_len - 1)];
      else
        id = 16'($urandom_range(0, 65535));
      fin = ($urandom_range(0, 3) != 0);
      send_req(op, id, fin);
    end
    wait_drained();
  endtask

  task automatic test_random();
    random_phase(275, 1'b1, 1'b1, 1'b0);
    random_phase(275, 1'b0, 1'b0, 1'b0);
    random_phase(275, 1'b1, 1'b0, 1'b1);
    random_phase(275, 1'b0, 1'b1, 1'b0);
  endtask

  // receiver holds off while requests keep coming, then sender waits it out
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    hold_len    = 80;
    repeat (12) send_req(op_e'($urandom_range(0, 3)), 16'($urandom), 1'($urandom));
    wait_drained();
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_req      <= '0;
    rst_n       <= 1'b0;
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    hold_len    = 0;
    ring_len    = 0;
    cur_pos     = 0;
    next_id     = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_ring();
    test_fill_to_full();
    test_retire_paths();
    test_churn();
    test_backpressure();
    test_random();
    test_backpressure();

    $display("ran %0d requests: %0d create, %0d schedule, %0d lookup, %0d retire",
             req_total, op_seen[OpCreate], op_seen[OpSchedule], op_seen[OpLookup],
             op_seen[OpRetire]);
    $display("full %0d, empty %0d, not found %0d, removed %0d, id wraps %0d, mismatches %0d",
             full_hits, empty_hits, miss_hits, removals, id_wraps, mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("round_robin_process_ring_core_test: clean");
    end else begin
      $display("round_robin_process_ring_core_test: errors");
    end
    $finish;
  end

endmodule
